[rtl/assert_macros.svh]
// assertion macros for the rtl files, included by gradient_noise_2d
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while in reset
`define GN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition that must never hold
`define GN_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

[rtl/gn2d_pkg.sv]
// types, constants and gradient helper for the 2d gradient noise block
// no dependencies
`timescale 1ns / 1ps

package gn2d_pkg;

  localparam int COORD_W = 24;
  localparam int BYTE_W  = 8;
  localparam int NOISE_W = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [21:0] FADE_C6  = 22'd6;
  localparam logic [21:0] FADE_C15 = 22'd15;
  localparam logic [21:0] FADE_C10 = 22'd10;

  localparam logic [3:0] H_U_SEL  = 4'd8;
  localparam logic [3:0] H_V_SEL  = 4'd4;
  localparam logic [3:0] H_VX_A   = 4'd12;
  localparam logic [3:0] H_VX_B   = 4'd14;

  localparam logic signed [17:0] ONE_Q16 = 18'sh10000;
  localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN = -16'sh8000;

  typedef struct packed {
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] x_coord;
    logic [BYTE_W-1:0]  table_value;
    logic [BYTE_W-1:0]  table_index;
  } gn2d_item_t;

  typedef struct packed {
    logic [3:0] h11;
    logic [3:0] h01;
    logic [3:0] h10;
    logic [3:0] h00;
  } gn2d_hash_t;

  function automatic logic signed [18:0] grad2(input logic [3:0] h,
                                               input logic signed [17:0] dx,
                                               input logic signed [17:0] dy);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < H_U_SEL) ? 19'(dx) : 19'(dy);
    if (h < H_V_SEL) begin
      v = 19'(dy);
    end else if (h == H_VX_A || h == H_VX_B) begin
      v = 19'(dx);
    end else begin
      v = '0;
    end
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

endpackage

[rtl/gn2d_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/gn2d_lookup.sv]
// cell split and three-level permutation hash over replicated table rams
// depends on gn2d_pkg and gn2d_ram
`timescale 1ns / 1ps

module gn2d_lookup #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                ld_i,
  input  logic                ev_i,
  input  gn2d_pkg::gn2d_item_t item_i,
  output logic                ev_o,
  output gn2d_pkg::gn2d_hash_t hash_o
);
  import gn2d_pkg::*;

  localparam int IDXW = $clog2(TABLE_SIZE);
  localparam int XW   = COORD_W + IDXW;

  function automatic logic [IDXW-1:0] to_idx(input logic [BYTE_W-1:0] b);
    return IDXW'(b);
  endfunction

  logic signed [XW-1:0] xe, ye;
  logic [IDXW-1:0] cx, cy;

  assign xe = XW'($signed(item_i.x_coord));
  assign ye = XW'($signed(item_i.y_coord));
  assign cx = xe[FRAC_BITS +: IDXW];
  assign cy = ye[FRAC_BITS +: IDXW];

  logic s1_ld_q, s1_ev_q, s2_ld_q, s2_ev_q, s3_ev_q;
  logic [IDXW-1:0]   s1_cy_q;
  logic [BYTE_W-1:0] s1_idx_q, s1_val_q, s2_idx_q, s2_val_q;

  logic [IDXW-1:0]   a_addr [2];
  logic [BYTE_W-1:0] a_data [2];
  logic [IDXW-1:0]   b_addr [4];
  logic [BYTE_W-1:0] b_data [4];
  logic [BYTE_W-1:0] c_data [4];
  logic [IDXW-1:0]   ha, hb;

  assign a_addr[0] = cx;
  assign a_addr[1] = cx + IDXW'(1);

  assign ha = to_idx(a_data[0]) + s1_cy_q;
  assign hb = to_idx(a_data[1]) + s1_cy_q;
  assign b_addr[0] = ha;
  assign b_addr[1] = hb;
  assign b_addr[2] = ha + IDXW'(1);
  assign b_addr[3] = hb + IDXW'(1);

  for (genvar i = 0; i < 2; i++) begin : g_tab_a
    gn2d_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk_i   (clk_i),
      .we_i    (en_i && ld_i),
      .waddr_i (to_idx(item_i.table_index)),
      .wdata_i (item_i.table_value),
      .re_i    (en_i),
      .raddr_i (a_addr[i]),
      .rdata_o (a_data[i])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_tab_b
    gn2d_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk_i   (clk_i),
      .we_i    (en_i && s1_ld_q),
      .waddr_i (to_idx(s1_idx_q)),
      .wdata_i (s1_val_q),
      .re_i    (en_i),
      .raddr_i (b_addr[i]),
      .rdata_o (b_data[i])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_tab_c
    gn2d_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_SIZE)) u_ram (
      .clk_i   (clk_i),
      .we_i    (en_i && s2_ld_q),
      .waddr_i (to_idx(s2_idx_q)),
      .wdata_i (s2_val_q),
      .re_i    (en_i),
      .raddr_i (to_idx(b_data[i])),
      .rdata_o (c_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ld_q <= 1'b0;
      s1_ev_q <= 1'b0;
      s2_ld_q <= 1'b0;
      s2_ev_q <= 1'b0;
      s3_ev_q <= 1'b0;
    end else if (en_i) begin
      s1_ld_q <= ld_i;
      s1_ev_q <= ev_i;
      s2_ld_q <= s1_ld_q;
      s2_ev_q <= s1_ev_q;
      s3_ev_q <= s2_ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cy_q  <= cy;
      s1_idx_q <= item_i.table_index;
      s1_val_q <= item_i.table_value;
      s2_idx_q <= s1_idx_q;
      s2_val_q <= s1_val_q;
    end
  end

  // corner order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
  assign hash_o.h00 = c_data[0][3:0];
  assign hash_o.h10 = c_data[1][3:0];
  assign hash_o.h01 = c_data[2][3:0];
  assign hash_o.h11 = c_data[3][3:0];
  assign ev_o = s3_ev_q;

endmodule

[rtl/gn2d_fade.sv]
// three-stage quintic fade of one coordinate fraction in q0.16
// depends on gn2d_pkg
`timescale 1ns / 1ps

module gn2d_fade #(
  parameter int FRAC_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [gn2d_pkg::COORD_W-1:0] coord_i,
  output logic [15:0]                  t_o,
  output logic [16:0]                  fade_o
);
  import gn2d_pkg::*;

  logic [FRAC_BITS-1:0] frac;
  logic [15:0] t0;
  logic [31:0] sq, cube;
  logic [21:0] q_d;
  logic [36:0] fprod;

  logic [15:0] t1_q, t2_q, t3_q, tc_q, tf_q;
  logic [20:0] q_q;
  logic [16:0] fade_q;

  assign frac  = coord_i[FRAC_BITS-1:0];
  assign t0    = 16'(frac) << (16 - FRAC_BITS);
  assign sq    = t0 * t0;
  assign cube  = t2_q * t1_q;
  assign q_d   = (FADE_C10 << 16) + FADE_C6 * 22'(t2_q) - FADE_C15 * 22'(t1_q);
  assign fprod = t3_q * q_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t0;
      t2_q   <= sq[31:16];
      tc_q   <= t1_q;
      t3_q   <= cube[31:16];
      q_q    <= q_d[20:0];
      tf_q   <= tc_q;
      fade_q <= fprod[32:16];
    end
  end

  assign t_o    = tf_q;
  assign fade_o = fade_q;

endmodule

[rtl/gn2d_blend.sv]
// corner gradients, two lerp levels and output scaling with saturation
// depends on gn2d_pkg
`timescale 1ns / 1ps

module gn2d_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 ev_i,
  input  gn2d_pkg::gn2d_hash_t hash_i,
  input  logic [15:0]          tx_i,
  input  logic [15:0]          ty_i,
  input  logic [16:0]          fu_i,
  input  logic [16:0]          fv_i,
  output logic                 valid_o,
  output logic [gn2d_pkg::NOISE_W-1:0] noise_o
);
  import gn2d_pkg::*;

  logic signed [17:0] dx0, dx1, dy0, dy1;

  assign dx0 = $signed({2'b00, tx_i});
  assign dy0 = $signed({2'b00, ty_i});
  assign dx1 = dx0 - ONE_Q16;
  assign dy1 = dy0 - ONE_Q16;

  logic v4_q, v5_q, v6_q, vo_q;
  logic signed [18:0] g00_q, g10_q, g01_q, g11_q;
  logic [16:0] fu4_q, fv4_q, fv5_q;
  logic signed [18:0] x0_q, x1_q, x06_q;
  logic signed [37:0] p6_q;
  logic [NOISE_W-1:0] noise_q;

  logic signed [19:0] d0, d1, d2;
  logic signed [37:0] p0, p1, p2;
  logic signed [19:0] x0_d, x1_d, r, r2;
  logic [NOISE_W-1:0] noise_d;

  assign d0 = 20'(g10_q) - 20'(g00_q);
  assign d1 = 20'(g11_q) - 20'(g01_q);
  assign p0 = $signed({1'b0, fu4_q}) * d0;
  assign p1 = $signed({1'b0, fu4_q}) * d1;
  assign x0_d = 20'(g00_q) + 20'(p0 >>> 16);
  assign x1_d = 20'(g01_q) + 20'(p1 >>> 16);

  assign d2 = 20'(x1_q) - 20'(x0_q);
  assign p2 = $signed({1'b0, fv5_q}) * d2;

  assign r  = 20'(x06_q) + 20'(p6_q >>> 16);
  assign r2 = r >>> 2;

  always_comb begin
    if (r2 > 20'(SAT_MAX)) begin
      noise_d = SAT_MAX;
    end else if (r2 < 20'(SAT_MIN)) begin
      noise_d = SAT_MIN;
    end else begin
      noise_d = r2[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= ev_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g00_q   <= grad2(hash_i.h00, dx0, dy0);
      g10_q   <= grad2(hash_i.h10, dx1, dy0);
      g01_q   <= grad2(hash_i.h01, dx0, dy1);
      g11_q   <= grad2(hash_i.h11, dx1, dy1);
      fu4_q   <= fu_i;
      fv4_q   <= fv_i;
      x0_q    <= 19'(x0_d);
      x1_q    <= 19'(x1_d);
      fv5_q   <= fv4_q;
      x06_q   <= x0_q;
      p6_q    <= p2;
      noise_q <= noise_d;
    end
  end

  assign valid_o = vo_q;
  assign noise_o = noise_q;

endmodule

[rtl/gradient_noise_2d.sv]
// top level of the 2d gradient noise block
// depends on gn2d_pkg, gn2d_lookup, gn2d_fade, gn2d_blend, assert_macros.svh
`timescale 1ns / 1ps

// Takes one word per clock and, with no back-pressure, returns the noise for
// each evaluate word in the order the words were accepted; load words give no
// output. The whole datapath is one pipeline with a common stall: the output
// register frees the input as soon as its word is taken. The permutation
// table is kept as ten copies in single-read rams, one per hash lookup; a
// load word writes each copy as it passes that copy's lookup stage, so words
// see the table exactly in arrival order. Load every entry before the first
// evaluate.

module gradient_noise_2d #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // table_index[7:0], table_value[15:8], x_coord[39:16], y_coord[63:40]
  input  logic [63:0] s_axis_tdata_i,
  // operation[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // noise_value[15:0]
  output logic [15:0] m_axis_tdata_o
);
  import gn2d_pkg::*;

  logic en, acc;
  logic s0_ld_q, s0_ev_q;
  gn2d_item_t s0_q;

  logic       ev3;
  gn2d_hash_t hash3;
  logic [15:0] tx3, ty3;
  logic [16:0] fu3, fv3;

  assign en  = !m_axis_tvalid_o || m_axis_tready_i;
  assign acc = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ld_q <= 1'b0;
      s0_ev_q <= 1'b0;
    end else if (en) begin
      s0_ld_q <= acc && (s_axis_tuser_i == OP_LOAD);
      s0_ev_q <= acc && (s_axis_tuser_i == OP_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s_axis_tdata_i;
    end
  end

  gn2d_lookup #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_lookup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ld_i   (s0_ld_q),
    .ev_i   (s0_ev_q),
    .item_i (s0_q),
    .ev_o   (ev3),
    .hash_o (hash3)
  );

  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (s0_q.x_coord),
    .t_o     (tx3),
    .fade_o  (fu3)
  );

  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (s0_q.y_coord),
    .t_o     (ty3),
    .fade_o  (fv3)
  );

  gn2d_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ev_i    (ev3),
    .hash_i  (hash3),
    .tx_i    (tx3),
    .ty_i    (ty3),
    .fu_i    (fu3),
    .fv_i    (fv3),
    .valid_o (m_axis_tvalid_o),
    .noise_o (m_axis_tdata_o)
  );

`include "assert_macros.svh"

  `GN_ASSERT_NEVER(a_ld_ev_excl, s0_ld_q && s0_ev_q)
  `GN_ASSERT(a_stall_holds_s0, !en |=> $stable(s0_q) && $stable(s0_ev_q))
  `GN_ASSERT(a_backpressure, m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)

endmodule

[bench/gradient_noise_2d_tb.sv]
// self-checking bench for gradient_noise_2d: loads permutation tables, then
// streams evaluate and load words under random gaps and stalls; depends on gn2d_pkg
`timescale 1ns / 1ps

module gradient_noise_2d_tb;
  import gn2d_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // table_index[7:0], table_value[15:8], x_coord[39:16], y_coord[63:40]
  logic [63:0] s_axis_tdata_i = '0;
  // operation[0]
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // noise_value[15:0]
  logic [15:0] m_axis_tdata_o;

  logic [7:0]         perm_copy [256];
  logic signed [15:0] noise_q [$];
  int                 mismatches = 0;
  int                 checked = 0;
  int                 loads_sent = 0;
  int                 evals_sent = 0;
  int                 burst_left = 0;

  gradient_noise_2d dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("gradient_noise_2d_tb: done, errors");
    $finish;
  end

  // receiver stall pattern: phases of free flow, of random stalls and of heavy stalling
  always @(posedge clk_i) begin
    if ((checked / 64) % 3 == 1) m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    else if ((checked / 64) % 3 == 2) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (noise_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata_o);
      end else begin
        logic signed [15:0] exp_n;
        exp_n = noise_q.pop_front();
        if (exp_n !== m_axis_tdata_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %h got %h", exp_n, m_axis_tdata_o);
        end
      end
      checked++;
    end
  end

  function automatic longint fade_q16(longint t);
    longint t2, t3, q;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    q = 6 * t2 - 15 * t + 10 * 65536;
    return (t3 * q) >>> 16;
  endfunction

  function automatic longint corner_dot(logic [3:0] h, longint dx, longint dy);
    longint u, v;
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint blend(longint f, longint a, longint b);
    return a + ((f * (b - a)) >>> 16);
  endfunction

  function automatic logic signed [15:0] noise_at(logic [23:0] x, logic [23:0] y);
    logic [7:0] cx, cy, a, b;
    longint tx, ty, fu, fv, g00, g10, g01, g11, r;
    cx = x[15:8];
    cy = y[15:8];
    tx = longint'(x[7:0]) << 8;
    ty = longint'(y[7:0]) << 8;
    fu = fade_q16(tx);
    fv = fade_q16(ty);
    a = perm_copy[cx] + cy;
    b = perm_copy[8'(cx + 1)] + cy;
    g00 = corner_dot(perm_copy[perm_copy[a]][3:0], tx, ty);
    g10 = corner_dot(perm_copy[perm_copy[b]][3:0], tx - 65536, ty);
    g01 = corner_dot(perm_copy[perm_copy[8'(a + 1)]][3:0], tx, ty - 65536);
    g11 = corner_dot(perm_copy[perm_copy[8'(b + 1)]][3:0], tx - 65536, ty - 65536);
    r = blend(fv, blend(fu, g00, g10), blend(fu, g01, g11)) >>> 2;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic send_word(logic op, logic [7:0] idx, logic [7:0] val,
                           logic [23:0] x, logic [23:0] y);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {y, x, val, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op == OP_LOAD) begin
      perm_copy[idx] = val;
      loads_sent++;
    end else begin
      noise_q.push_back(noise_at(x, y));
      evals_sent++;
    end
  endtask

  task automatic load_table(bit identity);
    int order [256];
    foreach (order[i]) order[i] = i;
    order.shuffle();
    foreach (order[i])
      send_word(OP_LOAD, 8'(order[i]), identity ? 8'(order[i]) : 8'($urandom),
                24'($urandom), 24'($urandom));
  endtask

  task automatic test_directed();
    logic [23:0] pts [10];
    pts = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff, 24'h0000ff,
            24'h000080, 24'hffff01, 24'h00ff00, 24'h000001, 24'h7fff80};
    load_table(1'b0);
    for (int i = 0; i < 10; i++)
      send_word(OP_EVAL, 8'($urandom), 8'($urandom), pts[i], pts[(i * 3 + 1) % 10]);
    // load after evaluate, rewriting the two entries that the next evaluate reads
    send_word(OP_LOAD, 8'hff, 8'h00, 24'h0, 24'h0);
    send_word(OP_LOAD, 8'h00, 8'hff, 24'h0, 24'h0);
    send_word(OP_EVAL, 8'h00, 8'h00, 24'hffff80, 24'h000080);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(OP_LOAD, 8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom));
      else
        send_word(OP_EVAL, 8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom));
    end
  endtask

  task automatic test_reload();
    load_table(1'b1);
    test_random(150);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(280);
    test_reload();
    s_axis_tvalid_i <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d loads and %0d evaluates, %0d results checked",
             loads_sent, evals_sent, checked);
    if (mismatches == 0 && noise_q.size() == 0)
      $display("gradient_noise_2d_tb: done, clean");
    else
      $display("gradient_noise_2d_tb: done, errors");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/gn2d_pkg.sv
rtl/gn2d_ram.sv
rtl/gn2d_lookup.sv
rtl/gn2d_fade.sv
rtl/gn2d_blend.sv
rtl/gradient_noise_2d.sv
bench/gradient_noise_2d_tb.sv
